FILE: hw/rtl/ppba_pkg.sv
// Shared types, codes and constants for the packed pixel buffer.
`default_nettype none

package ppba_pkg;

  // Field widths
  localparam int BPP_W    = 6;
  localparam int DIM_W    = 9;
  localparam int STRIDE_W = 11;
  localparam int IDX_W    = 16;
  localparam int COORD_W  = 8;
  localparam int COLOR_W  = 32;
  localparam int AREA_W   = 2 * DIM_W;
  localparam int BITPOS_W = DIM_W + BPP_W;

  // Register port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam logic [BPP_W-1:0] BPP_RST    = BPP_W'(24);
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(256);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_XY    = 2'd2,
    OP_FILL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_DEPTH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BPP    = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIZE,
    S_CHECK,
    S_DIV,
    S_POS,
    S_BYTE,
    S_CAP,
    S_DONE
  } state_e;

  // Effective configuration handed to the datapath
  typedef struct packed {
    logic [BPP_W-1:0]    bpp;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

  function automatic logic depth_ok(input logic [BPP_W-1:0] bd);
    unique case (bd)
      6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd24, 6'd32: depth_ok = 1'b1;
      default:                                       depth_ok = 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ppba_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module ppba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One access a cycle: write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ppba_div.sv
// Iterative restoring divider: pixel index split into row and column.
`default_nettype none

module ppba_div
  import ppba_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [IDX_W-1:0] dividend_i,
  input  wire logic [DIM_W-1:0] divisor_i,
  output      logic             done_o,
  output      logic [IDX_W-1:0] quotient_o,
  output      logic [DIM_W-1:0] remainder_o
);

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [IDX_W-1:0] quo_q, quo_d;
  logic [DIM_W-1:0] rem_q, rem_d;
  logic [DIM_W:0]   rem_sh;
  logic             fits;

  // One quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[IDX_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d = CNT_W'(IDX_W);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      quo_d = {quo_q[IDX_W-2:0], fits};
      rem_d = fits ? DIM_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[DIM_W-1:0];
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ppba_cfg.sv
// Configuration registers on the APB port, size saturation and row stride.
`default_nettype none

module ppba_cfg
  import ppba_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg_o
);

  logic [BPP_W-1:0]    bpp_q;
  logic [DIM_W-1:0]    width_q, height_q;
  logic [DIM_W-1:0]    width_eff, height_eff;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic [15:0]         bits_sum;
  logic                wr_en;
  reg_e                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[3:2]);

  // Register writes; unknown addresses are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= BPP_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BPP:    bpp_q    <= pwdata[BPP_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_BPP:    prdata = APB_DW'(bpp_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  // Sizes above the store limits saturate
  assign width_eff  = (32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
  assign height_eff = (32'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_q;

  // Stride: bits per row rounded up to whole 32-bit words, in bytes
  assign bits_sum = 16'(bpp_q * width_eff) + 16'd31;
  assign stride_d = {bits_sum[13:5], 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= '0;
    end else begin
      stride_q <= stride_d;
    end
  end

  assign cfg_o.bpp    = bpp_q;
  assign cfg_o.width  = width_eff;
  assign cfg_o.height = height_eff;
  assign cfg_o.stride = stride_q;

endmodule

`default_nettype wire

FILE: hw/rtl/packed_pixel_buffer_access.sv
// Packed pixel buffer: byte store with indexed read/write, x/y write and fill.
// Steps to done: an indexed command is sized, checked and divided into row and column,
// then a read or a sub-byte write passes S_BYTE and S_CAP per byte, a write at 8 bpp and up
// S_BYTE only; x/y skips the divider; fill repeats this per pixel; errors end at S_CHECK.
// One word at a time: busy stays high through done, the next start is taken once back in S_IDLE.
// Reset: depth 24, 256 x 256, idle; store undefined until written; receiver cannot stall.
`default_nettype none

module packed_pixel_buffer_access
  import ppba_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output      logic [APB_DW-1:0]  prdata,
  output      logic               pready,
  // command
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [IDX_W-1:0]   pixel_index_i,
  input  wire logic [COORD_W-1:0] column_i,
  input  wire logic [COORD_W-1:0] row_i,
  input  wire logic [COLOR_W-1:0] color_i,
  // result
  output      logic               done_o,
  output      logic [COLOR_W-1:0] read_color_o,
  output      logic [1:0]         status_o
);

  localparam int DEPTH = MAX_WIDTH * 4 * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  cfg_t   cfg;
  state_e state_q, state_d;

  op_e                 op_q;
  logic [IDX_W-1:0]    idx_q;
  logic [COORD_W-1:0]  col_q, row_q;
  logic [COLOR_W-1:0]  color_q;
  logic [AREA_W-1:0]   wh_q;
  logic [DIM_W-1:0]    c_q, r_q;
  logic [1:0]          k_q;
  logic [BITPOS_W-1:0] bitpos_q;
  logic [AW-1:0]       rowoff_q;
  logic [COLOR_W-1:0]  acc_q, acc_nx;
  logic [COLOR_W-1:0]  rc_q;
  status_e             st_q;

  logic                div_start, div_done;
  logic [IDX_W-1:0]    div_quo;
  logic [DIM_W-1:0]    div_rem;

  logic                ram_en, ram_we;
  logic [AW-1:0]       ram_addr, base_addr;
  logic [7:0]          ram_wdata, ram_rdata;

  logic                is_write, wide, k_last_hit, last_pixel, idx_bad, xy_bad;
  logic [1:0]          k_last;
  logic [2:0]          shift;
  logic [7:0]          nmask, pmask, merged, narrow_px;

  ppba_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  ppba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (idx_q),
    .divisor_i  (cfg.width),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  ppba_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Decode of the current operation
  assign is_write   = (op_q != OP_READ);
  assign wide       = (cfg.bpp[5:3] != 3'd0);
  assign k_last     = 2'(cfg.bpp[5:3] - 3'd1);
  assign k_last_hit = (k_q == k_last);
  assign last_pixel = (op_q != OP_FILL) ||
                      ((c_q == cfg.width - DIM_W'(1)) && (r_q == cfg.height - DIM_W'(1)));
  assign idx_bad    = ({{(AREA_W-IDX_W){1'b0}}, idx_q} >= wh_q);
  assign xy_bad     = ({1'b0, col_q} >= cfg.width) || ({1'b0, row_q} >= cfg.height);

  // Byte address and sub-byte position
  assign base_addr = rowoff_q + AW'(bitpos_q[BITPOS_W-1:3]) + AW'(k_q);
  assign shift     = bitpos_q[2:0];
  assign nmask     = (8'd1 << cfg.bpp[2:0]) - 8'd1;
  assign pmask     = nmask << shift;
  assign merged    = (ram_rdata & ~pmask) | ((color_q[7:0] & nmask) << shift);
  assign narrow_px = (ram_rdata >> shift) & nmask;

  // Read assembly, little-endian
  always_comb begin
    acc_nx = acc_q;
    acc_nx[8*k_q +: 8] = ram_rdata;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) state_d = S_SIZE;
      S_SIZE:  state_d = S_CHECK;
      S_CHECK: begin
        if (!depth_ok(cfg.bpp)) begin
          state_d = S_DONE;
        end else begin
          unique case (op_q) inside
            OP_READ, OP_WRITE: state_d = idx_bad ? S_DONE : S_DIV;
            OP_XY:             state_d = xy_bad ? S_DONE : S_POS;
            OP_FILL:           state_d = (wh_q == '0) ? S_DONE : S_POS;
            default:           state_d = S_DONE;
          endcase
        end
      end
      S_DIV:   if (div_done) state_d = S_POS;
      S_POS:   state_d = S_BYTE;
      S_BYTE: begin
        if (wide && is_write) begin
          if (k_last_hit) state_d = last_pixel ? S_DONE : S_POS;
        end else begin
          state_d = S_CAP;
        end
      end
      S_CAP: begin
        if (!is_write && wide && !k_last_hit) begin
          state_d = S_BYTE;
        end else begin
          state_d = last_pixel ? S_DONE : S_POS;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = base_addr;
    ram_wdata = color_q[8*k_q +: 8];
    div_start = 1'b0;
    unique case (state_q)
      S_CHECK: div_start = depth_ok(cfg.bpp) && !idx_bad &&
                           ((op_q == OP_READ) || (op_q == OP_WRITE));
      S_BYTE: begin
        ram_en = 1'b1;
        ram_we = wide && is_write;
      end
      S_CAP: begin
        ram_en    = is_write && !wide;
        ram_we    = 1'b1;
        ram_wdata = merged;
      end
      default: ;
    endcase
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_DONE);
  assign read_color_o = rc_q;
  assign status_o     = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_q    <= op_e'(operation_i);
          idx_q   <= pixel_index_i;
          col_q   <= column_i;
          row_q   <= row_i;
          color_q <= color_i;
          rc_q    <= '0;
          acc_q   <= '0;
          st_q    <= STAT_OK;
        end
      end
      S_SIZE: wh_q <= cfg.width * cfg.height;
      S_CHECK: begin
        if (!depth_ok(cfg.bpp)) begin
          st_q <= STAT_DEPTH;
        end else if (op_q == OP_XY) begin
          if (xy_bad) st_q <= STAT_RANGE;
          c_q <= {1'b0, col_q};
          r_q <= {1'b0, row_q};
        end else if (op_q == OP_FILL) begin
          c_q <= '0;
          r_q <= '0;
        end else if (idx_bad) begin
          st_q <= STAT_RANGE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          c_q <= div_rem;
          r_q <= div_quo[DIM_W-1:0];
        end
      end
      S_POS: begin
        bitpos_q <= c_q * cfg.bpp;
        rowoff_q <= AW'(r_q * cfg.stride);
        k_q      <= '0;
      end
      S_BYTE: begin
        if (wide && is_write && !k_last_hit) k_q <= k_q + 2'd1;
      end
      S_CAP: begin
        if (!is_write) begin
          acc_q <= acc_nx;
          if (wide) begin
            k_q <= k_q + 2'd1;
            if (k_last_hit) rc_q <= acc_nx;
          end else begin
            rc_q <= {{(COLOR_W-8){1'b0}}, narrow_px};
          end
        end
      end
      default: ;
    endcase

    // Fill walks the image row by row
    if (op_q == OP_FILL && !last_pixel &&
        ((state_q == S_BYTE && wide && is_write && k_last_hit) ||
         (state_q == S_CAP && !wide))) begin
      if (c_q == cfg.width - DIM_W'(1)) begin
        c_q <= '0;
        r_q <= r_q + DIM_W'(1);
      end else begin
        c_q <= c_q + DIM_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/packed_pixel_buffer_access_tb.sv
`timescale 1ns / 100ps
// Testbench for the packed pixel buffer: commands checked against a byte-level image model.
module packed_pixel_buffer_access_tb
  import ppba_pkg::*;
();

  localparam int STORE_BYTES   = DEF_MAX_WIDTH * 4 * DEF_MAX_HEIGHT;
  localparam int FILL_AREA_MAX = 256;      // fills only on small images, they write w*h pixels
  localparam int SPOTS_MAX     = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [APB_AW-1:0] SPARE_ADDR = APB_AW'(12);  // slot past the last register

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    status_e            status;
  } pixel_result_t;

  // Image model: byte store with a per-bit written map, plus outstanding result words
  class pixel_store_scoreboard;
    bit [7:0]      store_data  [STORE_BYTES];
    bit [7:0]      store_known [STORE_BYTES];
    int unsigned   bpp    = BPP_RST;
    int unsigned   width  = WIDTH_RST;
    int unsigned   height = HEIGHT_RST;
    int unsigned   stride;
    pixel_result_t expected_words [$];
    int unsigned   failures;

    function new();
      update_stride();
    endfunction

    function void update_stride();
      stride = (((bpp * active_width() + 31) / 32) * 4) & 'h7FF;
    endfunction

    function int unsigned active_width();
      return (width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width;
    endfunction

    function int unsigned active_height();
      return (height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height;
    endfunction

    function bit depth_supported();
      return bpp inside {1, 2, 4, 8, 16, 24, 32};
    endfunction

    function bit [31:0] depth_mask();
      return (bpp >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bpp) - 32'd1);
    endfunction

    // register write; unknown slots are dropped
    function void set_reg(logic [1:0] slot, logic [APB_DW-1:0] value);
      case (reg_e'(slot))
        REG_BPP:    bpp    = value[BPP_W-1:0];
        REG_WIDTH:  width  = value[DIM_W-1:0];
        REG_HEIGHT: height = value[DIM_W-1:0];
        default:    return;
      endcase
      update_stride();
    endfunction

    function void put_pixel(int unsigned c, int unsigned r, bit [31:0] color);
      int unsigned addr, sh, k;
      bit [31:0]   v;
      bit [7:0]    m;
      addr = r * stride + (c * bpp) / 8;
      v    = color & depth_mask();
      if (bpp >= 8) begin
        for (k = 0; k < bpp / 8; k++) begin
          store_data[addr + k]  = v[8*k +: 8];
          store_known[addr + k] = 8'hFF;
        end
      end else begin
        // sub-byte depths: LSB-first packing, other pixels' bits kept
        sh = bpp * (c % (8 / bpp));
        m  = 8'(depth_mask() << sh);
        store_data[addr]  = (store_data[addr] & ~m) | (8'(v << sh) & m);
        store_known[addr] = store_known[addr] | m;
      end
    endfunction

    // pixel value; returns 1 only when every bit it covers has been written
    function bit fetch_pixel(int unsigned c, int unsigned r, output bit [31:0] value);
      int unsigned addr, sh, k;
      bit [7:0]    m;
      bit          known;
      addr  = r * stride + (c * bpp) / 8;
      value = '0;
      known = 1'b1;
      if (bpp >= 8) begin
        for (k = 0; k < bpp / 8; k++) begin
          value[8*k +: 8] = store_data[addr + k];
          known = known && (store_known[addr + k] == 8'hFF);
        end
      end else begin
        sh    = bpp * (c % (8 / bpp));
        m     = 8'(depth_mask() << sh);
        value = (32'(store_data[addr]) >> sh) & depth_mask();
        known = ((store_known[addr] & m) == m);
      end
      return known;
    endfunction

    function void note_command(op_e op, logic [IDX_W-1:0] idx, logic [COORD_W-1:0] col,
                               logic [COORD_W-1:0] row, logic [COLOR_W-1:0] color);
      pixel_result_t word;
      int unsigned   w, h, c, r;
      bit [31:0]     value;
      word = '0;
      w    = active_width();
      h    = active_height();
      // depth check wins over the range check
      if (!depth_supported()) begin
        word.status = STAT_DEPTH;
      end else begin
        case (op)
          OP_READ, OP_WRITE: begin
            if (w == 0 || idx >= w * h) begin
              word.status = STAT_RANGE;
            end else if (op == OP_READ) begin
              void'(fetch_pixel(idx % w, idx / w, value));
              word.read_color = value;
            end else begin
              put_pixel(idx % w, idx / w, color);
            end
          end
          OP_XY: begin
            if (col >= w || row >= h) word.status = STAT_RANGE;
            else put_pixel(col, row, color);
          end
          OP_FILL: begin
            for (r = 0; r < h; r++)
              for (c = 0; c < w; c++)
                put_pixel(c, r, color);
          end
        endcase
      end
      expected_words.push_back(word);
    endfunction

    function void check_word(logic [COLOR_W-1:0] read_color, logic [1:0] status);
      pixel_result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing outstanding: read_color %h, status %0d",
               read_color, status);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      if (read_color !== want.read_color) begin
        $error("read_color: expected %h, actual %h", want.read_color, read_color);
        failures++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel, penable, pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         operation_i;
  logic [IDX_W-1:0]   pixel_index_i;
  logic [COORD_W-1:0] column_i;
  logic [COORD_W-1:0] row_i;
  logic [COLOR_W-1:0] color_i;
  logic               done_o;
  logic [COLOR_W-1:0] read_color_o;
  logic [1:0]         status_o;

  pixel_store_scoreboard sb;
  int unsigned           written_spots [$];   // in-range indices written in this layout
  int unsigned           depth_choices [7] = '{1, 2, 4, 8, 16, 24, 32};
  int unsigned           cycle_count;

  packed_pixel_buffer_access i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .pixel_index_i (pixel_index_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .color_i       (color_i),
    .done_o        (done_o),
    .read_color_o  (read_color_o),
    .status_o      (status_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result words
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) sb.check_word(read_color_o, status_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(addr[APB_AW-1:2], data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // drop start and wait until every word has come back and the block is idle
  task automatic finish_outstanding();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.expected_words.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned bpp, int unsigned w, int unsigned h);
    finish_outstanding();
    apb_write({REG_BPP, 2'b00}, bpp);
    apb_write({REG_WIDTH, 2'b00}, w);
    apb_write({REG_HEIGHT, 2'b00}, h);
    written_spots.delete();
  endtask

  task automatic pause_commands(int unsigned cycles);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic issue(op_e op, logic [IDX_W-1:0] idx, logic [COORD_W-1:0] col,
                       logic [COORD_W-1:0] row, logic [COLOR_W-1:0] color);
    @(negedge clk_i);
    start_i       = 1'b1;
    operation_i   = op;
    pixel_index_i = idx;
    column_i      = col;
    row_i         = row;
    color_i       = color;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_command(op, idx, col, row, color);
  endtask

  function automatic int unsigned pick_dimension();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return 0;
          1:       return 1;
          2:       return 256;
          default: return 511;
        endcase
      end
      1:       return $urandom_range(257, 511);
      2:       return $urandom_range(1, 256);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // one random command; reads inside the image only touch pixels already written
  task automatic random_command(bit with_gaps);
    op_e                op;
    int unsigned        w, h, area, pick, tries;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] col, row;
    logic [COLOR_W-1:0] color;
    bit [31:0]          scratch;
    bit                 ok;
    w     = sb.active_width();
    h     = sb.active_height();
    area  = w * h;
    idx   = IDX_W'($urandom);
    col   = COORD_W'($urandom);
    row   = COORD_W'($urandom);
    case ($urandom_range(9))
      0:       color = '0;
      1:       color = '1;
      default: color = $urandom;
    endcase
    pick = $urandom_range(99);
    if (pick < 40)      op = OP_READ;
    else if (pick < 65) op = OP_WRITE;
    else if (pick < 92) op = OP_XY;
    else                op = OP_FILL;
    if (op == OP_FILL && area > FILL_AREA_MAX && sb.depth_supported()) op = OP_XY;

    case (op)
      OP_READ: begin
        ok = !sb.depth_supported();
        if (!ok && area > 0 && $urandom_range(7) != 0) begin
          for (tries = 0; tries < 8 && !ok; tries++) begin
            if (written_spots.size() > 0 && $urandom_range(3) != 0)
              idx = IDX_W'(written_spots[$urandom_range(written_spots.size() - 1)]);
            else
              idx = IDX_W'($urandom_range(area - 1));
            ok = sb.fetch_pixel(idx % w, idx / w, scratch);
          end
        end
        // nothing safe to read: ask beyond the image, or write instead
        if (!ok) begin
          if (area < 65536) idx = IDX_W'($urandom_range(65535, area));
          else op = OP_WRITE;
        end
      end
      OP_WRITE: begin
        if (area > 0 && $urandom_range(7) != 0) idx = IDX_W'($urandom_range(area - 1));
      end
      OP_XY: begin
        if (area > 0 && $urandom_range(7) != 0) begin
          col = COORD_W'($urandom_range(w - 1));
          row = COORD_W'($urandom_range(h - 1));
        end
      end
      default: ;
    endcase

    // remember written pixels so later reads hit real data
    if (sb.depth_supported()) begin
      if (op == OP_WRITE && idx < area) written_spots.push_back(idx);
      if (op == OP_XY && col < w && row < h) written_spots.push_back(row * w + col);
      if (written_spots.size() > SPOTS_MAX) void'(written_spots.pop_front());
    end

    if (with_gaps && $urandom_range(3) == 0) pause_commands($urandom_range(1, 11));
    issue(op, idx, col, row, color);
  endtask

  initial begin
    int unsigned p, n, i, bd, w, h;
    sb            = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    start_i       = 1'b0;
    operation_i   = OP_READ;
    pixel_index_i = '0;
    column_i      = '0;
    row_i         = '0;
    color_i       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset layout: 24 bpp, 256 x 256, corner pixels
    issue(OP_WRITE, 16'd0,     8'd0,   8'd0,   32'hFFFF_FFFF);
    issue(OP_WRITE, 16'hFFFF,  8'd0,   8'd0,   32'h12AB_CDEF);
    issue(OP_READ,  16'd0,     8'd0,   8'd0,   32'd0);
    issue(OP_READ,  16'hFFFF,  8'd0,   8'd0,   32'd0);
    issue(OP_XY,    16'd0,     8'hFF,  8'hFF,  32'd0);
    issue(OP_READ,  16'hFFFF,  8'd0,   8'd0,   32'd0);
    issue(OP_XY,    16'd0,     8'd0,   8'd1,   32'h5A5A_5A5A);
    issue(OP_READ,  16'd256,   8'd0,   8'd0,   32'd0);

    // 1 bpp, 3 x 2: padded rows, sub-byte packing, range checks
    configure(1, 3, 2);
    issue(OP_FILL,  16'd0,     8'd0,   8'd0,   32'hFFFF_FFFF);
    issue(OP_XY,    16'd0,     8'd1,   8'd0,   32'd0);
    issue(OP_READ,  16'd1,     8'd0,   8'd0,   32'd0);
    issue(OP_READ,  16'd2,     8'd0,   8'd0,   32'd0);
    issue(OP_READ,  16'd5,     8'd0,   8'd0,   32'd0);
    issue(OP_READ,  16'd6,     8'd0,   8'd0,   32'd0);
    issue(OP_XY,    16'd0,     8'd3,   8'd0,   32'd1);
    issue(OP_XY,    16'd0,     8'd0,   8'd2,   32'd1);

    // unsupported depth; a write to the unused slot changes nothing
    configure(63, 3, 2);
    issue(OP_READ,  16'd0,     8'd0,   8'd0,   32'd0);
    issue(OP_FILL,  16'd0,     8'd0,   8'd0,   32'd1);
    issue(OP_WRITE, 16'd1,     8'd0,   8'd0,   32'd1);
    finish_outstanding();
    apb_write(SPARE_ADDR, $urandom);
    issue(OP_READ,  16'd0,     8'd0,   8'd0,   32'd0);

    // empty image, then oversized width saturating to one full row
    configure(32, 0, 511);
    issue(OP_FILL,  16'd0,     8'd0,   8'd0,   32'hFFFF_FFFF);
    issue(OP_READ,  16'd0,     8'd0,   8'd0,   32'd0);
    issue(OP_XY,    16'd0,     8'd0,   8'd0,   32'd7);
    configure(32, 511, 1);
    issue(OP_FILL,  16'd0,     8'd0,   8'd0,   32'hDEAD_BEEF);
    issue(OP_READ,  16'd255,   8'd0,   8'd0,   32'd0);
    issue(OP_WRITE, 16'd256,   8'd0,   8'd0,   32'd3);

    // random layouts; the last phases run without gaps
    for (p = 0; p < 24; p++) begin
      if ($urandom_range(99) < 85) bd = depth_choices[$urandom_range(6)];
      else bd = $urandom_range(63);
      w = pick_dimension();
      h = pick_dimension();
      if (p == 0) begin
        w = 256;
        h = 256;
      end else if (p == 1) begin
        w = 1;
        h = 1;
      end
      configure(bd, w, h);
      n = $urandom_range(18, 34);
      for (i = 0; i < n; i++) random_command(p < 20);
    end

    finish_outstanding();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ppba_pkg.sv
hw/rtl/ppba_ram.sv
hw/rtl/ppba_div.sv
hw/rtl/ppba_cfg.sv
hw/rtl/packed_pixel_buffer_access.sv
dv/packed_pixel_buffer_access_tb.sv
